// ===== src/hcf_pkg.sv =====
// Shared types, constants and helpers of the hex checksum command framer.
`default_nettype none
package hcf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_CHAR = 1'd0;
  localparam cfg_idx_t CFG_END_CHAR   = 1'd1;

  localparam byte_t START_CHAR_RESET = 8'h53;
  localparam byte_t END_CHAR_RESET   = 8'h0D;

  localparam byte_t HEX_DIGIT_BASE   = 8'h30;
  localparam byte_t HEX_LETTER_OFFSET = 8'd55;

  typedef enum logic [3:0] {
    PH_START,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BYTE,
    PH_END,
    PH_XOR_HI,
    PH_XOR_LO,
    PH_SUM_HI,
    PH_SUM_LO
  } phase_t;

  function automatic byte_t hex_digit(input logic [3:0] v);
    byte_t d;
    d = {4'd0, v};
    if (v < 4'd10) begin
      hex_digit = d + HEX_DIGIT_BASE;
    end else begin
      hex_digit = d + HEX_LETTER_OFFSET;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/hcf_if.sv =====
// Valid/ready channel interfaces for command items and framed characters.
`default_nettype none
interface hcf_in_if;
  logic                 valid;
  logic                 ready;
  hcf_pkg::byte_t       cmd_byte;
  hcf_pkg::byte_t       cmd_length;
  logic                 last_byte;

  modport source (output valid, cmd_byte, cmd_length, last_byte, input ready);
  modport sink   (input valid, cmd_byte, cmd_length, last_byte, output ready);
endinterface

interface hcf_out_if;
  logic                 valid;
  logic                 ready;
  hcf_pkg::byte_t       out_byte;
  logic                 run_last;
  logic                 frame_last;

  modport source (output valid, out_byte, run_last, frame_last, input ready);
  modport sink   (input valid, out_byte, run_last, frame_last, output ready);
endinterface
`default_nettype wire

// ===== src/hex_checksum_command_framer.sv =====
// Top level of the hex checksum command framer.
//
// Each command character is taken into an input register and its frame characters leave
// through a result register, one per cycle unless the output stalls. A middle character
// of a command gives one result, so characters stream at one per cycle when unstalled;
// the opening character gives the start character, two length digits and the character,
// and the final one gives the character, terminator, two XOR digits and two sum digits,
// or all of them for a one-character command, from the single result register and its
// one-character-per-cycle phase sequencer. The next item is taken in the cycle its
// predecessor's last result enters the result register, while that result waits.
`default_nettype none
module hex_checksum_command_framer (
  input  wire                   clk,
  input  wire                   rst_n,
  hcf_in_if.sink                in_if,
  hcf_out_if.source             out_if,
  input  wire                   cfg_we,
  input  wire hcf_pkg::cfg_idx_t cfg_index,
  input  wire hcf_pkg::byte_t   cfg_data
);
  import hcf_pkg::*;

  byte_t  start_char_r, end_char_r;
  logic   hold_valid_r;
  byte_t  hold_byte_r, hold_len_r;
  logic   hold_last_r;
  phase_t phase_r, phase_nxt, phase_adv;
  logic   in_frame_r, in_frame_nxt;
  byte_t  xor_r, xor_nxt, sum_r, sum_nxt;
  logic   out_valid_r;
  byte_t  out_byte_r;
  logic   out_run_last_r, out_frame_last_r;

  logic   emit, in_accept, item_done, checked;
  byte_t  emit_char;

  assign emit      = hold_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !hold_valid_r || (emit && item_done);
  assign in_accept = in_if.valid && in_if.ready;

  always_comb begin
    phase_adv = phase_r;
    item_done = 1'b0;
    unique case (phase_r)
      PH_START:  phase_adv = PH_LEN_HI;
      PH_LEN_HI: phase_adv = PH_LEN_LO;
      PH_LEN_LO: phase_adv = PH_BYTE;
      PH_BYTE: begin
        if (hold_last_r) begin
          phase_adv = PH_END;
        end else begin
          item_done = 1'b1;
        end
      end
      PH_END:    phase_adv = PH_XOR_HI;
      PH_XOR_HI: phase_adv = PH_XOR_LO;
      PH_XOR_LO: phase_adv = PH_SUM_HI;
      PH_SUM_HI: phase_adv = PH_SUM_LO;
      PH_SUM_LO: item_done = 1'b1;
      default:   phase_adv = PH_START;
    endcase
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    if (emit && phase_r == PH_START) begin
      in_frame_nxt = 1'b1;
    end else if (emit && phase_r == PH_SUM_LO) begin
      in_frame_nxt = 1'b0;
    end
    phase_nxt = phase_r;
    if (in_accept) begin
      phase_nxt = in_frame_nxt ? PH_BYTE : PH_START;
    end else if (emit) begin
      phase_nxt = phase_adv;
    end
  end

  always_comb begin
    emit_char = hold_byte_r;
    checked   = 1'b1;
    unique case (phase_r)
      PH_START:  emit_char = start_char_r;
      PH_LEN_HI: emit_char = hex_digit(hold_len_r[7:4]);
      PH_LEN_LO: emit_char = hex_digit(hold_len_r[3:0]);
      PH_BYTE:   emit_char = hold_byte_r;
      PH_END:    emit_char = end_char_r;
      PH_XOR_HI: begin
        emit_char = hex_digit(xor_r[7:4]);
        checked   = 1'b0;
      end
      PH_XOR_LO: begin
        emit_char = hex_digit(xor_r[3:0]);
        checked   = 1'b0;
      end
      PH_SUM_HI: begin
        emit_char = hex_digit(sum_r[7:4]);
        checked   = 1'b0;
      end
      PH_SUM_LO: begin
        emit_char = hex_digit(sum_r[3:0]);
        checked   = 1'b0;
      end
      default:   emit_char = hold_byte_r;
    endcase
    xor_nxt = xor_r;
    sum_nxt = sum_r;
    if (emit && phase_r == PH_START) begin
      xor_nxt = emit_char;
      sum_nxt = emit_char;
    end else if (emit && checked) begin
      xor_nxt = xor_r ^ emit_char;
      sum_nxt = sum_r + emit_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RESET;
      end_char_r   <= END_CHAR_RESET;
      hold_valid_r <= 1'b0;
      phase_r      <= PH_START;
      in_frame_r   <= 1'b0;
      xor_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_CHAR: start_char_r <= cfg_data;
          CFG_END_CHAR:   end_char_r   <= cfg_data;
          default:        start_char_r <= start_char_r;
        endcase
      end
      if (in_accept) begin
        hold_valid_r <= 1'b1;
      end else if (emit && item_done) begin
        hold_valid_r <= 1'b0;
      end
      phase_r    <= phase_nxt;
      in_frame_r <= in_frame_nxt;
      xor_r      <= xor_nxt;
      sum_r      <= sum_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_byte_r <= in_if.cmd_byte;
      hold_len_r  <= in_if.cmd_length;
      hold_last_r <= in_if.last_byte;
    end
    if (emit) begin
      out_byte_r       <= emit_char;
      out_run_last_r   <= item_done;
      out_frame_last_r <= (phase_r == PH_SUM_LO);
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_byte   = out_byte_r;
  assign out_if.run_last   = out_run_last_r;
  assign out_if.frame_last = out_frame_last_r;

endmodule
`default_nettype wire

// ===== src/hcf_checker.sv =====
// Port-level assertions for the hex checksum command framer, bound to its top level.
`default_nettype none
module hcf_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire hcf_pkg::byte_t out_byte,
  input wire                 run_last,
  input wire                 frame_last
);
  import hcf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last) && $stable(frame_last))
    else $error("stalled result item changed");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_last |-> run_last)
    else $error("frame ended without ending the item's results");

  a_accept_yields: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item produced no result");

endmodule

bind hex_checksum_command_framer hcf_checker u_hcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .run_last   (out_if.run_last),
  .frame_last (out_if.frame_last)
);
`default_nettype wire

// ===== verif/hex_checksum_command_framer_test.sv =====
// Self-checking testbench of the hex checksum command framer: directed table, then random frames.
`default_nettype none
module hex_checksum_command_framer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 320;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SETTLE_CYCLES  = 20;

  typedef struct packed {
    byte_t ch;
    logic  run_last;
    logic  frame_last;
  } frame_char_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    byte_t       b;
    byte_t       len;
    logic        last;
    logic [3:0]  n_typed;
    logic [71:0] typed;
  } stim_row_t;

  stim_row_t dir_rows [24] = '{
    '{ROW_ITEM, CFG_START_CHAR, 8'h41, 8'h01, 1'b1, 4'd9, 72'h53_30_31_41_0D_31_45_30_32},
    '{ROW_ITEM, CFG_START_CHAR, 8'h48, 8'h02, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h49, 8'h37, 1'b1, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'hFF, 8'hFF, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h00, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h7E, 8'hAB, 1'b1, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h00, 8'h00, 1'b1, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_START_CHAR, 8'h00, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_END_CHAR,   8'h00, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h00, 8'h00, 1'b1, 4'd9, 72'h00_30_30_00_00_30_30_36_30},
    '{ROW_CFG,  CFG_START_CHAR, 8'hFF, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_END_CHAR,   8'hFF, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'hFF, 8'hFF, 1'b1, 4'd9, 72'hFF_46_46_FF_FF_46_46_38_39},
    '{ROW_CFG,  CFG_START_CHAR, 8'h53, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_END_CHAR,   8'h0D, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h61, 8'h03, 1'b0, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_END_CHAR,   8'h0A, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h62, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_START_CHAR, 8'h21, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h63, 8'h00, 1'b1, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h7A, 8'h10, 1'b1, 4'd0, 72'h0},
    '{ROW_CFG,  CFG_END_CHAR,   8'h0D, 8'h00, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'h5A, 8'hC9, 1'b0, 4'd0, 72'h0},
    '{ROW_ITEM, CFG_START_CHAR, 8'hA5, 8'h00, 1'b1, 4'd0, 72'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  byte_t       cfg_data;

  hcf_in_if  in_ch ();
  hcf_out_if out_ch ();

  hex_checksum_command_framer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_char_t frame_chars_q [$];
  logic        pr_in_frame;
  byte_t       pr_xor;
  byte_t       pr_sum;
  byte_t       pr_start;
  byte_t       pr_end;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sent_items;
  int unsigned mismatches;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic byte_t to_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return {4'h3, nib};
    end
    return {4'h0, nib} + 8'd55;
  endfunction

  task automatic put_char(input byte_t ch, input logic checked, input logic is_final);
    frame_chars_q.push_back('{ch, 1'b0, is_final});
    if (checked) begin
      pr_xor = pr_xor ^ ch;
      pr_sum = pr_sum + ch;
    end
  endtask

  task automatic frame_predict(input byte_t b, input byte_t len, input logic last);
    byte_t x;
    byte_t s;
    if (!pr_in_frame) begin
      pr_xor = '0;
      pr_sum = '0;
      put_char(pr_start, 1'b1, 1'b0);
      put_char(to_hex(len[7:4]), 1'b1, 1'b0);
      put_char(to_hex(len[3:0]), 1'b1, 1'b0);
      pr_in_frame = 1'b1;
    end
    put_char(b, 1'b1, 1'b0);
    if (last) begin
      put_char(pr_end, 1'b1, 1'b0);
      x = pr_xor;
      s = pr_sum;
      put_char(to_hex(x[7:4]), 1'b0, 1'b0);
      put_char(to_hex(x[3:0]), 1'b0, 1'b0);
      put_char(to_hex(s[7:4]), 1'b0, 1'b0);
      put_char(to_hex(s[3:0]), 1'b0, 1'b1);
      pr_in_frame = 1'b0;
      pr_xor = '0;
      pr_sum = '0;
    end
    frame_chars_q[frame_chars_q.size() - 1].run_last = 1'b1;
  endtask

  task automatic send_cmd(input byte_t b, input byte_t len, input logic last,
                          input int n_typed, input logic [71:0] typed);
    int base;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.cmd_byte   = b;
    in_ch.cmd_length = len;
    in_ch.last_byte  = last;
    do @(posedge clk); while (!in_ch.ready);
    frame_predict(b, len, last);
    base = frame_chars_q.size() - n_typed;
    for (int k = 0; k < n_typed; k++) begin
      frame_chars_q[base + k].ch = typed[8 * (n_typed - 1 - k) +: 8];
    end
    sent_items++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (frame_chars_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input byte_t d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_START_CHAR: pr_start = d;
      CFG_END_CHAR:   pr_end   = d;
      default: ;
    endcase
  endtask

  task automatic send_random_frame();
    int unsigned n;
    byte_t       len;
    n   = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
    len = ($urandom_range(4) == 0) ? byte_t'($urandom_range(255)) : byte_t'(n);
    for (int i = 0; i < int'(n); i++) begin
      send_cmd(byte_t'($urandom_range(255)), (i == 0) ? len : byte_t'($urandom_range(255)),
               i == int'(n) - 1, 0, '0);
      if ($urandom_range(49) == 0) begin
        drain();
      end
    end
  endtask

  task automatic note_mismatch(input string what, input frame_char_t want,
                               input frame_char_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected byte %h run_last %b frame_last %b, got byte %h run_last %b frame_last %b",
               $realtime, what, want.ch, want.run_last, want.frame_last,
               got.ch, got.run_last, got.frame_last);
    end
  endtask

  always @(posedge clk) begin
    frame_char_t got;
    frame_char_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.run_last, out_ch.frame_last};
      if (frame_chars_q.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        want = frame_chars_q.pop_front();
        if (got.ch !== want.ch || got.run_last !== want.run_last ||
            got.frame_last !== want.frame_last) begin
          note_mismatch("wrong item", want, got);
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_START_CHAR;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd_byte   = '0;
    in_ch.cmd_length = '0;
    in_ch.last_byte  = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    sent_items       = 0;
    mismatches       = 0;
    idle_cycles      = 0;
    pr_in_frame      = 1'b0;
    pr_xor           = '0;
    pr_sum           = '0;
    pr_start         = START_CHAR_RESET;
    pr_end           = END_CHAR_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].idx, dir_rows[r].b);
      end else begin
        send_cmd(dir_rows[r].b, dir_rows[r].len, dir_rows[r].last,
                 int'(dir_rows[r].n_typed), dir_rows[r].typed);
      end
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_reg(CFG_START_CHAR, byte_t'($urandom_range(255)));
          write_reg(CFG_END_CHAR, byte_t'($urandom_range(255)));
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
          write_reg(CFG_START_CHAR, 8'h00);
          write_reg(CFG_END_CHAR, 8'hFF);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
          write_reg(CFG_START_CHAR, 8'hFF);
          write_reg(CFG_END_CHAR, 8'h00);
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
          write_reg(CFG_START_CHAR, byte_t'($urandom_range(255)));
          write_reg(CFG_END_CHAR, byte_t'($urandom_range(255)));
        end
      endcase
      while (sent_items < ITEM_TARGET * (p + 1) / 4) send_random_frame();
    end

    while (frame_chars_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
